FILE: rtl/rcpd_pkg.sv
// Shared types and constants for the RC pulse and PPM decoder.
// Holds the configuration record, mode codes and register indexes.
// No dependencies.
`default_nettype none

package rcpd_pkg;

   localparam int TIME_W    = 16;
   localparam int CHAN_W    = 4;
   localparam int PPM_CH_W  = 5;
   localparam int WIDTH_W   = 15;
   localparam int FACTOR_W  = 3;
   localparam int COUNT_W   = 16;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   typedef enum logic [1:0] {
      MODE_PWM     = 2'd0,
      MODE_PPM     = 2'd1,
      MODE_PPM_ALL = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_DECODE_MODE   = 3'd0,
      REG_TIMER_FACTOR  = 3'd1,
      REG_SYNC_MIN      = 3'd2,
      REG_PPM_COUNT     = 3'd3,
      REG_FS_CHANNEL    = 3'd4,
      REG_FS_MIN        = 3'd5,
      REG_FS_MAX        = 3'd6,
      REG_PPM_INVERTED  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [1:0]           decode_mode;
      logic [FACTOR_W-1:0]  timer_factor;
      logic [TIME_W-1:0]    sync_min_width;
      logic [PPM_CH_W-1:0]  ppm_channel_count;
      logic [CHAN_W-1:0]    failsafe_channel;
      logic [WIDTH_W-1:0]   failsafe_min;
      logic [WIDTH_W-1:0]   failsafe_max;
      logic                 ppm_inverted;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      decode_mode:       2'd0,
      timer_factor:      3'd2,
      sync_min_width:    16'd7000,
      ppm_channel_count: 5'd8,
      failsafe_channel:  4'd1,
      failsafe_min:      15'd0,
      failsafe_max:      15'd32767,
      ppm_inverted:      1'b0
   };

endpackage

`default_nettype wire

FILE: rtl/rcpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Parameters set width and depth. No dependencies.
`default_nettype none

module rcpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rcpd_csr.sv
// Configuration register bank of the RC pulse decoder, written over an APB-style port.
// Depends on rcpd_pkg for the register record and register indexes.
`default_nettype none

module rcpd_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rcpd_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [rcpd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [rcpd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready,
   output rcpd_pkg::cfg_type                cfg
);

   rcpd_pkg::cfg_type       cfg_ff;
   rcpd_pkg::cfg_type       cfg_in;
   rcpd_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = rcpd_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rcpd_pkg::REG_DECODE_MODE:  cfg_in.decode_mode       = csr_pwdata[1:0];
            rcpd_pkg::REG_TIMER_FACTOR: cfg_in.timer_factor      = csr_pwdata[2:0];
            rcpd_pkg::REG_SYNC_MIN:     cfg_in.sync_min_width    = csr_pwdata[15:0];
            rcpd_pkg::REG_PPM_COUNT:    cfg_in.ppm_channel_count = csr_pwdata[4:0];
            rcpd_pkg::REG_FS_CHANNEL:   cfg_in.failsafe_channel  = csr_pwdata[3:0];
            rcpd_pkg::REG_FS_MIN:       cfg_in.failsafe_min      = csr_pwdata[14:0];
            rcpd_pkg::REG_FS_MAX:       cfg_in.failsafe_max      = csr_pwdata[14:0];
            rcpd_pkg::REG_PPM_INVERTED: cfg_in.ppm_inverted      = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rcpd_pkg::REG_DECODE_MODE:  csr_prdata = 32'(cfg_ff.decode_mode);
         rcpd_pkg::REG_TIMER_FACTOR: csr_prdata = 32'(cfg_ff.timer_factor);
         rcpd_pkg::REG_SYNC_MIN:     csr_prdata = 32'(cfg_ff.sync_min_width);
         rcpd_pkg::REG_PPM_COUNT:    csr_prdata = 32'(cfg_ff.ppm_channel_count);
         rcpd_pkg::REG_FS_CHANNEL:   csr_prdata = 32'(cfg_ff.failsafe_channel);
         rcpd_pkg::REG_FS_MIN:       csr_prdata = 32'(cfg_ff.failsafe_min);
         rcpd_pkg::REG_FS_MAX:       csr_prdata = 32'(cfg_ff.failsafe_max);
         rcpd_pkg::REG_PPM_INVERTED: csr_prdata = 32'(cfg_ff.ppm_inverted);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rcpd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/rc_pulse_ppm_decoder_unit.sv
// RC pulse decoder top level: request pipeline, rise-time RAM, PPM frame
// tracking, scaling and failsafe counters. Depends on rcpd_pkg, rcpd_ram, rcpd_csr.
//
// Usage:
// Each request carries one capture event (timer value, pin level, capture
// channel). Every request gives exactly one response: the decoded width, if
// any, the failsafe counters after the event and a frame sync flag.
// A request is taken when req_valid is high and req_stall is low. The rise
// times sit in a RAM that is read on acceptance; in the next cycle the decode
// stage decodes the event and loads the response register, which drives
// rsp_valid; while rsp_stall holds the previous response, the event waits.
// One request per cycle is sustained while rsp_stall is low; that figure is
// set by the single RAM read port, read once per request, and a write-to-read
// bypass covers a rise time written by the previous request.
// When rsp_stall holds the response, an empty decode stage still takes one
// request; once it holds one, req_stall stays high until the response moves.
// Reset clears the pipeline, the PPM frame state, the counters and the
// rise-time valid bits, so unwritten rise times read as zero. There is no
// clearing pass. Configuration is written over the csr_ port, pready always
// high, and is meant to change only while no request is in flight.
`default_nettype none

module rc_pulse_ppm_decoder_unit #(
   parameter int NUM_CHANNELS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [rcpd_pkg::TIME_W-1:0]      req_capture_time,
   input  wire logic                             req_pin_level,
   input  wire logic [rcpd_pkg::CHAN_W-1:0]      req_capture_channel,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_width_valid,
   output logic      [rcpd_pkg::CHAN_W-1:0]      rsp_width_channel,
   output logic      [rcpd_pkg::WIDTH_W-1:0]     rsp_width_value,
   output logic      [rcpd_pkg::COUNT_W-1:0]     rsp_good_pulse_count,
   output logic      [rcpd_pkg::COUNT_W-1:0]     rsp_noise_pulse_count,
   output logic                                  rsp_frame_sync,
   // configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rcpd_pkg::CSR_AW-1:0]      csr_paddr,
   input  wire logic [rcpd_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic      [rcpd_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [rcpd_pkg::CHAN_W-1:0]   NUM_CH_C  = rcpd_pkg::CHAN_W'(NUM_CHANNELS);
   localparam logic [rcpd_pkg::PPM_CH_W-1:0] NUM_CH_P  = rcpd_pkg::PPM_CH_W'(NUM_CHANNELS);
   localparam logic [17:0]                   SAT_LIMIT = 18'd32767;

   rcpd_pkg::cfg_type cfg;

   rcpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- accept stage: issue the rise-time read ----------------
   logic                         req_accept;
   logic [rcpd_pkg::CHAN_W-1:0]  req_cap_m1;
   logic [CH_AW-1:0]             req_addr;
   logic                         req_cap_ok;

   assign req_accept = req_valid && !req_stall;
   assign req_cap_m1 = req_capture_channel - rcpd_pkg::CHAN_W'(1);
   assign req_addr   = req_cap_m1[CH_AW-1:0];
   assign req_cap_ok = (req_capture_channel != '0) && (req_capture_channel <= NUM_CH_C);

   // ---------------- decode stage registers ----------------
   logic                         s1_valid_ff, s1_valid_in;
   logic [rcpd_pkg::TIME_W-1:0]  s1_time_ff;
   logic                         s1_level_ff;
   logic [rcpd_pkg::CHAN_W-1:0]  s1_cap_ff;
   logic [CH_AW-1:0]             s1_addr_ff;
   logic                         s1_cap_ok_ff;
   logic                         s1_fire;

   logic                         rsp_valid_ff, rsp_valid_in;

   assign s1_fire     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_fire;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_time_ff   <= req_capture_time;
         s1_level_ff  <= req_pin_level;
         s1_cap_ff    <= req_capture_channel;
         s1_addr_ff   <= req_addr;
         s1_cap_ok_ff <= req_cap_ok;
      end
   end

   // ---------------- rise-time memory with valid bits and bypass ----------------
   logic                         ram_wr_en;
   logic [rcpd_pkg::TIME_W-1:0]  ram_rd_data;
   logic [NUM_CHANNELS-1:0]      rise_vld_ff, rise_vld_in;
   logic                         fwd_valid_ff;
   logic [CH_AW-1:0]             fwd_addr_ff;
   logic [rcpd_pkg::TIME_W-1:0]  fwd_data_ff;
   logic [rcpd_pkg::TIME_W-1:0]  rise_time;

   rcpd_ram #(
      .WIDTH (rcpd_pkg::TIME_W),
      .DEPTH (NUM_CHANNELS)
   ) u_rise_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_time_ff),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // The RAM returns old data when the previous request wrote the same entry
   // in the cycle of this read, so that write is replayed from a register.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         rise_time = fwd_data_ff;
      end else if (rise_vld_ff[s1_addr_ff]) begin
         rise_time = ram_rd_data;
      end else begin
         rise_time = '0;
      end
   end

   always_comb begin
      rise_vld_in = rise_vld_ff;
      if (ram_wr_en) begin
         rise_vld_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_vld_ff  <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         rise_vld_ff <= rise_vld_in;
         if (s1_fire) begin
            fwd_valid_ff <= ram_wr_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= s1_time_ff;
      end
   end

   // ---------------- decode ----------------
   logic [rcpd_pkg::TIME_W-1:0]   ppm_last_ff, ppm_last_in;
   logic [rcpd_pkg::PPM_CH_W-1:0] ppm_next_ff, ppm_next_in;
   logic [rcpd_pkg::COUNT_W-1:0]  good_ff, good_in;
   logic [rcpd_pkg::COUNT_W-1:0]  noise_ff, noise_in;

   logic                          active;
   logic [rcpd_pkg::TIME_W-1:0]   ppm_raw;
   logic                          ppm_is_sync;
   logic                          ppm_in_frame;
   logic                          deliver;
   logic [rcpd_pkg::PPM_CH_W-1:0] deliver_ch;
   logic [rcpd_pkg::TIME_W-1:0]   deliver_raw;
   logic                          sync;
   logic                          advance;
   logic [18:0]                   product;
   logic [17:0]                   half;
   logic [rcpd_pkg::WIDTH_W-1:0]  scaled;
   logic                          in_window;
   logic                          fs_hit;

   assign active       = s1_level_ff != cfg.ppm_inverted;
   assign ppm_raw      = s1_time_ff - ppm_last_ff;
   assign ppm_is_sync  = ppm_raw > cfg.sync_min_width;
   assign ppm_in_frame = (ppm_next_ff != '0) && (ppm_next_ff <= cfg.ppm_channel_count);

   always_comb begin
      deliver     = 1'b0;
      deliver_ch  = '0;
      deliver_raw = ppm_raw;
      sync        = 1'b0;
      advance     = 1'b0;
      ram_wr_en   = 1'b0;
      ppm_last_in = ppm_last_ff;
      case (rcpd_pkg::mode_type'(cfg.decode_mode))
         rcpd_pkg::MODE_PWM: begin
            if (s1_cap_ok_ff) begin
               if (s1_level_ff) begin
                  ram_wr_en = s1_fire;
               end else begin
                  deliver     = 1'b1;
                  deliver_ch  = rcpd_pkg::PPM_CH_W'(s1_cap_ff);
                  deliver_raw = s1_time_ff - rise_time;
               end
            end
         end
         rcpd_pkg::MODE_PPM: begin
            if (active) begin
               ppm_last_in = s1_time_ff;
               if (ppm_is_sync) begin
                  sync = 1'b1;
               end else begin
                  advance = ppm_in_frame;
               end
            end
         end
         rcpd_pkg::MODE_PPM_ALL: begin
            ppm_last_in = s1_time_ff;
            if (active) begin
               sync = ppm_is_sync;
            end else begin
               advance = ppm_in_frame;
            end
         end
         default: begin
         end
      endcase
      if (advance && (ppm_next_ff <= NUM_CH_P)) begin
         deliver    = 1'b1;
         deliver_ch = ppm_next_ff;
      end
   end

   always_comb begin
      if (sync) begin
         ppm_next_in = rcpd_pkg::PPM_CH_W'(1);
      end else if (advance) begin
         ppm_next_in = ppm_next_ff + rcpd_pkg::PPM_CH_W'(1);
      end else begin
         ppm_next_in = ppm_next_ff;
      end
   end

   // Width scaled by factor/2 with saturation at the 15-bit maximum.
   assign product   = 19'(deliver_raw) * 19'(cfg.timer_factor);
   assign half      = product[18:1];
   assign scaled    = (half > SAT_LIMIT) ? rcpd_pkg::WIDTH_W'(SAT_LIMIT) : half[14:0];
   assign in_window = (scaled > cfg.failsafe_min) && (scaled < cfg.failsafe_max);
   assign fs_hit    = deliver && (deliver_ch == rcpd_pkg::PPM_CH_W'(cfg.failsafe_channel));

   always_comb begin
      good_in  = good_ff;
      noise_in = noise_ff;
      if (fs_hit) begin
         if (in_window) begin
            good_in = good_ff + rcpd_pkg::COUNT_W'(1);
         end else begin
            noise_in = noise_ff + rcpd_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_last_ff <= '0;
         ppm_next_ff <= '0;
         good_ff     <= '0;
         noise_ff    <= '0;
      end else if (s1_fire) begin
         ppm_last_ff <= ppm_last_in;
         ppm_next_ff <= ppm_next_in;
         good_ff     <= good_in;
         noise_ff    <= noise_in;
      end
   end

   // ---------------- response register ----------------
   logic                          rsp_wv_ff;
   logic [rcpd_pkg::CHAN_W-1:0]   rsp_ch_ff;
   logic [rcpd_pkg::WIDTH_W-1:0]  rsp_w_ff;
   logic [rcpd_pkg::COUNT_W-1:0]  rsp_good_ff;
   logic [rcpd_pkg::COUNT_W-1:0]  rsp_noise_ff;
   logic                          rsp_sync_ff;

   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_wv_ff    <= deliver;
         rsp_ch_ff    <= deliver ? deliver_ch[rcpd_pkg::CHAN_W-1:0] : '0;
         rsp_w_ff     <= deliver ? scaled : '0;
         rsp_good_ff  <= good_in;
         rsp_noise_ff <= noise_in;
         rsp_sync_ff  <= sync;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_width_valid       = rsp_wv_ff;
   assign rsp_width_channel     = rsp_ch_ff;
   assign rsp_width_value       = rsp_w_ff;
   assign rsp_good_pulse_count  = rsp_good_ff;
   assign rsp_noise_pulse_count = rsp_noise_ff;
   assign rsp_frame_sync        = rsp_sync_ff;

`ifndef ASSERT_OFF
   // A request is only held back while a finished response is being stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && s1_valid_ff))
      else $error("request stalled without a stalled response");

   // A delivered width always names a channel, and never comes with a sync gap.
   a_width_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_width_valid) |-> ((rsp_width_channel != '0) && !rsp_frame_sync))
      else $error("width response without channel or together with sync");

   // The failsafe counters only move when a request leaves the decode stage.
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ((good_ff != $past(good_ff)) || (noise_ff != $past(noise_ff))))
         |-> $past(s1_fire)
      ) else $error("failsafe counter changed without a decoded request");

   // A rise-time write only happens on a request that leaves the decode stage.
   a_ram_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (s1_fire && s1_cap_ok_ff && s1_level_ff))
      else $error("rise-time write outside a decoded rising edge");
`endif

endmodule

`default_nettype wire
